// ----- rtl/tga_rle_pkg.sv -----
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; every other file of the block but tga_rle_if imports this package.

package tga_rle_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PRESENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd3;

    // Packet header split and default alpha
    localparam logic [7:0] RUN_HEADER_BIAS = 8'd127;
    localparam logic [7:0] ALPHA_OPAQUE    = 8'hFF;

    // Settings handed from the register file to the decoder
    typedef struct packed {
        logic        rle_mode;
        logic        alpha_present;
        logic [31:0] pixel_count;
    } tga_cfg_t;

endpackage

// ----- rtl/tga_rle_if.sv -----
// Channel interfaces of the TGA run-length pixel decoder: byte in, pixel out.
// Depends on nothing; valid/ready handshake, one beat per edge with both high.

interface tga_rle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface tga_rle_pix_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [31:0] first_pixel_index;
    logic        image_done;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output run_length, output first_pixel_index, output image_done,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input run_length, input first_pixel_index, input image_done,
                    output ready);
endinterface

// ----- rtl/tga_rle_pixel_decoder.sv -----
// Top level of the TGA run-length pixel decoder.
// Depends on tga_rle_pkg, tga_rle_if, tga_rle_cfg and tga_rle_dec.
//
//   channel  dir  payload                                   beat
//   byte_in  in   data_byte[7:0]                            one stored byte
//   pix_out  out  red, green, blue, alpha, run_length,      one pixel or run
//                 first_pixel_index[31:0], image_done
//   cfg_*    in   cfg_index[1:0], cfg_wdata[15:0]           one register write
//
// One byte per cycle while byte_in is not held off; a pixel appears on pix_out in the cycle after its last byte.
// A single result register sits on pix_out; while it holds a beat that is not
// taken, byte_in is held off, whatever the next byte would do.
// Reset clears all control state but not the result payload; image size reads 1x1, uncompressed, no alpha.
// A register write takes effect at the next cycle, pixel count included.

module tga_rle_pixel_decoder
    import tga_rle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    tga_rle_byte_if.sink          byte_in,
    tga_rle_pix_if.source         pix_out
);

    tga_cfg_t cfg;

    tga_rle_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tga_rle_dec u_dec
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .byte_in (byte_in),
        .pix_out (pix_out)
    );

    // Never stall input while the result stage is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !pix_out.valid |-> byte_in.ready)
        else $error("byte_in stalled with empty result stage");

    // A result always covers between one and 128 pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid |-> (pix_out.run_length != 8'd0) && (pix_out.run_length <= 8'd128))
        else $error("run_length out of range");

    // Nothing follows the beat that ends the image
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && pix_out.ready && pix_out.image_done) |=> !pix_out.valid)
        else $error("result after end of image");

endmodule

// ----- rtl/tga_rle_cfg.sv -----
// Configuration register file of the TGA run-length pixel decoder.
// Depends on tga_rle_pkg; keeps the image pixel count in step with each write.

module tga_rle_cfg
    import tga_rle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output tga_cfg_t              cfg
);

    logic        rle_mode_reg,      rle_mode_next;
    logic        alpha_present_reg, alpha_present_next;
    logic [15:0] width_reg,         width_next;
    logic [15:0] height_reg,        height_next;
    logic [31:0] count_reg,         count_next;

    // Decode the write and form the product from the values being written
    always_comb
    begin
        rle_mode_next      = rle_mode_reg;
        alpha_present_next = alpha_present_reg;
        width_next         = width_reg;
        height_next        = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RLE_MODE:      rle_mode_next      = cfg_wdata[0];
                REG_ALPHA_PRESENT: alpha_present_next = cfg_wdata[0];
                REG_IMAGE_WIDTH:   width_next         = cfg_wdata;
                REG_IMAGE_HEIGHT:  height_next        = cfg_wdata;
                default:           ;
            endcase
        end
        count_next = {16'd0, width_next} * {16'd0, height_next};
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_mode_reg      <= 1'b0;
            alpha_present_reg <= 1'b0;
            width_reg         <= 16'd1;
            height_reg        <= 16'd1;
            count_reg         <= 32'd1;
        end
        else
        begin
            rle_mode_reg      <= rle_mode_next;
            alpha_present_reg <= alpha_present_next;
            width_reg         <= width_next;
            height_reg        <= height_next;
            count_reg         <= count_next;
        end
    end

    assign cfg.rle_mode      = rle_mode_reg;
    assign cfg.alpha_present = alpha_present_reg;
    assign cfg.pixel_count   = count_reg;

endmodule

// ----- rtl/tga_rle_dec.sv -----
// Byte decoder of the TGA run-length pixel decoder: packet and pixel state,
// one-pass update per byte beat, and the registered result stage.
// Depends on tga_rle_pkg and the channel interfaces in tga_rle_if.

module tga_rle_dec
    import tga_rle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  tga_cfg_t     cfg,
    tga_rle_byte_if.sink byte_in,
    tga_rle_pix_if.source pix_out
);

    localparam logic [1:0] PH_BLUE  = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_RED   = 2'd2;
    localparam logic [1:0] PH_ALPHA = 2'd3;

    // Decoder state
    logic [1:0]  phase_reg,    phase_next;
    logic [23:0] colour_reg,   colour_next;
    logic [7:0]  remain_reg,   remain_next;
    logic        is_run_reg,   is_run_next;
    logic [31:0] emitted_reg,  emitted_next;
    logic        finished_reg, finished_next;

    // Result stage
    logic        valid_reg,    valid_next;
    logic [23:0] res_colour_reg;
    logic [7:0]  res_alpha_reg;
    logic [7:0]  res_len_reg;
    logic [31:0] res_index_reg;
    logic        res_done_reg;

    logic        in_fire;
    logic        live;
    logic        pixel_done;
    logic [7:0]  b;
    logic [7:0]  alpha_val;
    logic [7:0]  len;
    logic        done;
    logic [31:0] left;

    assign b       = byte_in.data_byte;
    assign in_fire = byte_in.valid && byte_in.ready;
    assign left    = cfg.pixel_count - emitted_reg;
    assign live    = !finished_reg && (emitted_reg < cfg.pixel_count);

    // Take the next beat whenever the result stage is empty or draining
    assign byte_in.ready = !valid_reg || pix_out.ready;

    // Advance packet and pixel state for one byte
    always_comb
    begin
        phase_next    = phase_reg;
        colour_next   = colour_reg;
        remain_next   = remain_reg;
        is_run_next   = is_run_reg;
        emitted_next  = emitted_reg;
        finished_next = finished_reg;
        pixel_done    = 1'b0;
        alpha_val     = ALPHA_OPAQUE;
        len           = 8'd1;
        done          = 1'b0;

        if (in_fire && live)
        begin
            if (cfg.rle_mode && (remain_reg == 8'd0))
            begin
                // Packet header: drop any partial pixel
                phase_next = PH_BLUE;
                if (!b[7])
                begin
                    remain_next = b + 8'd1;
                    is_run_next = 1'b0;
                end
                else
                begin
                    remain_next = b - RUN_HEADER_BIAS;
                    is_run_next = 1'b1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_BLUE:
                    begin
                        colour_next[7:0] = b;
                        phase_next       = PH_GREEN;
                    end
                    PH_GREEN:
                    begin
                        colour_next[15:8] = b;
                        phase_next        = PH_RED;
                    end
                    PH_RED:
                    begin
                        colour_next[23:16] = b;
                        if (cfg.alpha_present)
                            phase_next = PH_ALPHA;
                        else
                            pixel_done = 1'b1;
                    end
                    PH_ALPHA:
                    begin
                        alpha_val  = cfg.alpha_present ? b : ALPHA_OPAQUE;
                        pixel_done = 1'b1;
                    end
                    default: ;
                endcase

                if (pixel_done)
                begin
                    phase_next = PH_BLUE;
                    done       = (left == 32'd1);
                    if (cfg.rle_mode)
                    begin
                        if (is_run_reg)
                        begin
                            // Cut the run at the end of the image
                            if ({24'd0, remain_reg} >= left)
                            begin
                                len  = left[7:0];
                                done = 1'b1;
                            end
                            else
                            begin
                                len  = remain_reg;
                                done = 1'b0;
                            end
                            remain_next = 8'd0;
                        end
                        else
                        begin
                            remain_next = remain_reg - 8'd1;
                        end
                    end
                    emitted_next = emitted_reg + {24'd0, len};
                    if (done)
                        finished_next = 1'b1;
                end
            end
        end
    end

    // Result valid: load on a finished pixel, clear once taken
    always_comb
    begin
        if (pixel_done)
            valid_next = 1'b1;
        else if (pix_out.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_BLUE;
            colour_reg   <= 24'd0;
            remain_reg   <= 8'd0;
            is_run_reg   <= 1'b0;
            emitted_reg  <= 32'd0;
            finished_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            colour_reg   <= colour_next;
            remain_reg   <= remain_next;
            is_run_reg   <= is_run_next;
            emitted_reg  <= emitted_next;
            finished_reg <= finished_next;
            valid_reg    <= valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (pixel_done)
        begin
            res_colour_reg <= colour_next;
            res_alpha_reg  <= alpha_val;
            res_len_reg    <= len;
            res_index_reg  <= emitted_reg;
            res_done_reg   <= done;
        end
    end

    assign pix_out.valid             = valid_reg;
    assign pix_out.red               = res_colour_reg[23:16];
    assign pix_out.green             = res_colour_reg[15:8];
    assign pix_out.blue              = res_colour_reg[7:0];
    assign pix_out.alpha             = res_alpha_reg;
    assign pix_out.run_length        = res_len_reg;
    assign pix_out.first_pixel_index = res_index_reg;
    assign pix_out.image_done        = res_done_reg;

endmodule
